### hdl/tpp_pkg.sv
// Package with the phase type, byte class and status codes, and the stage item types.
`default_nettype none
package tpp_pkg;

  typedef enum logic [3:0] {
    PH_OPC_HI  = 4'd0,
    PH_OPC_LO  = 4'd1,
    PH_FNAME   = 4'd2,
    PH_MODE    = 4'd3,
    PH_ONAME   = 4'd4,
    PH_OVAL    = 4'd5,
    PH_WHI     = 4'd6,
    PH_WLO     = 4'd7,
    PH_PAYLOAD = 4'd8,
    PH_MESSAGE = 4'd9,
    PH_TRAILER = 4'd10,
    PH_IGNORE  = 4'd11
  } phase_t;

  localparam logic [3:0] CLS_OPCODE  = 4'd0;
  localparam logic [3:0] CLS_WORD    = 4'd1;
  localparam logic [3:0] CLS_FNAME   = 4'd2;
  localparam logic [3:0] CLS_MODE    = 4'd3;
  localparam logic [3:0] CLS_ONAME   = 4'd4;
  localparam logic [3:0] CLS_OVAL    = 4'd5;
  localparam logic [3:0] CLS_PAYLOAD = 4'd6;
  localparam logic [3:0] CLS_MESSAGE = 4'd7;
  localparam logic [3:0] CLS_TERM    = 4'd8;
  localparam logic [3:0] CLS_IGNORED = 4'd9;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BADOP = 2'd1;
  localparam logic [1:0] ST_MAL   = 2'd2;

  localparam logic [15:0] OPC_RRQ   = 16'd1;
  localparam logic [15:0] OPC_WRQ   = 16'd2;
  localparam logic [15:0] OPC_DATA  = 16'd3;
  localparam logic [15:0] OPC_ACK   = 16'd4;
  localparam logic [15:0] OPC_ERROR = 16'd5;
  localparam logic [15:0] OPC_OACK  = 16'd6;

  localparam logic [3:0] OIDX_MAX = 4'd15;
  localparam logic [1:0] TRAILER_MAX = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_item_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [3:0]  byte_class;
    logic [3:0]  option_index;
    logic        packet_end;
    logic [15:0] opcode;
    logic [15:0] word_value;
    logic [4:0]  option_count;
    logic [1:0]  status;
  } result_t;

endpackage
`default_nettype wire

### hdl/tpp_if.sv
// Interfaces for the packet byte channel and the classification result channel.
`default_nettype none
interface tpp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tpp_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_out;
  logic [3:0]  byte_class;
  logic [3:0]  option_index;
  logic        packet_end;
  logic [15:0] opcode;
  logic [15:0] word_value;
  logic [4:0]  option_count;
  logic [1:0]  status;

  modport source (output valid, output byte_out, output byte_class, output option_index,
                  output packet_end, output opcode, output word_value,
                  output option_count, output status, input ready);
  modport sink (input valid, input byte_out, input byte_class, input option_index,
                input packet_end, input opcode, input word_value,
                input option_count, input status, output ready);
endinterface
`default_nettype wire

### hdl/tftp_packet_parser_unit.sv
// Top level of the TFTP packet byte classifier.
//
// Channel   Direction  Payload
// bytes     sink       data_byte[7:0], last_byte
// results   source     byte_out, byte_class, option_index, packet_end, opcode,
//                      word_value, option_count, status
//
// One result per byte, one byte per cycle sustained while results do not stall;
// each byte moves from the input register to the result register that offers it.
// Synchronous reset clears both stage valid bits and returns the phase machine
// to the opcode high byte; the machine also returns there after each last byte.
// A stall on results holds the result register, and a new byte is taken
// whenever the input register is empty or moves on in the same cycle.
`default_nettype none
module tftp_packet_parser_unit #(
  parameter int MAX_OPTIONS = 16
) (
  input  wire logic    clk,
  input  wire logic    rst,
  tpp_byte_if.sink     bytes,
  tpp_result_if.source results
);

  logic                advance;
  logic                item_valid;
  tpp_pkg::byte_item_t item;

  tpp_input_stage u_input (
    .clk        (clk),
    .rst        (rst),
    .bytes      (bytes),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  tpp_classifier #(
    .MAX_OPTIONS (MAX_OPTIONS)
  ) u_classifier (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .results    (results)
  );

endmodule
`default_nettype wire

### hdl/tpp_input_stage.sv
// Input register that holds one packet byte until the classifier takes it.
`default_nettype none
module tpp_input_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  tpp_byte_if.sink                bytes,
  input  wire logic               advance,
  output logic                    item_valid,
  output tpp_pkg::byte_item_t     item
);

  assign bytes.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (bytes.ready) begin
      item_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      item.data_byte <= bytes.data_byte;
      item.last_byte <= bytes.last_byte;
    end
  end

endmodule
`default_nettype wire

### hdl/tpp_classifier.sv
// Packet phase machine, per-byte classification and the result register.
`default_nettype none
module tpp_classifier #(
  parameter int MAX_OPTIONS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  input  wire tpp_pkg::byte_item_t item,
  output logic                    advance,
  tpp_result_if.source            results
);

  localparam int CNT_NEED = $clog2(MAX_OPTIONS + 1);
  localparam int CW = (CNT_NEED > 5) ? CNT_NEED : 5;

  tpp_pkg::phase_t phase, phase_next;
  logic [15:0]     opcode_reg, opcode_upd, opcode_next;
  logic [15:0]     word_reg, word_upd, word_next;
  logic [CW-1:0]   option_counter, counter_upd, counter_next;
  logic [1:0]      error_flag, error_upd, error_next;
  logic [1:0]      trailer_count, trailer_upd, trailer_next;
  logic [3:0]      cls;
  logic [3:0]      oidx;
  logic [1:0]      endst;
  logic            is_zero;
  logic            take;
  logic            res_valid;
  tpp_pkg::result_t res, res_next;

  assign advance = !res_valid || results.ready;
  assign take = item_valid && advance;
  assign is_zero = (item.data_byte == 8'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= tpp_pkg::PH_OPC_HI;
      opcode_reg     <= '0;
      word_reg       <= '0;
      option_counter <= '0;
      error_flag     <= '0;
      trailer_count  <= '0;
    end else if (take) begin
      phase          <= phase_next;
      opcode_reg     <= opcode_next;
      word_reg       <= word_next;
      option_counter <= counter_next;
      error_flag     <= error_next;
      trailer_count  <= trailer_next;
    end
  end

  always_comb begin
    phase_next  = phase;
    opcode_upd  = opcode_reg;
    word_upd    = word_reg;
    counter_upd = option_counter;
    error_upd   = error_flag;
    trailer_upd = trailer_count;
    cls         = tpp_pkg::CLS_IGNORED;
    oidx        = 4'd0;
    endst       = tpp_pkg::ST_MAL;
    unique case (phase)
      tpp_pkg::PH_OPC_HI: begin
        cls        = tpp_pkg::CLS_OPCODE;
        opcode_upd = {item.data_byte, 8'd0};
        phase_next = tpp_pkg::PH_OPC_LO;
      end
      tpp_pkg::PH_OPC_LO: begin
        cls        = tpp_pkg::CLS_OPCODE;
        opcode_upd = {opcode_reg[15:8], item.data_byte};
        if (opcode_upd == tpp_pkg::OPC_RRQ || opcode_upd == tpp_pkg::OPC_WRQ) begin
          phase_next = tpp_pkg::PH_FNAME;
        end else if (opcode_upd == tpp_pkg::OPC_DATA || opcode_upd == tpp_pkg::OPC_ACK ||
                     opcode_upd == tpp_pkg::OPC_ERROR) begin
          phase_next = tpp_pkg::PH_WHI;
        end else if (opcode_upd == tpp_pkg::OPC_OACK) begin
          phase_next = tpp_pkg::PH_ONAME;
        end else begin
          error_upd  = tpp_pkg::ST_BADOP;
          phase_next = tpp_pkg::PH_IGNORE;
        end
      end
      tpp_pkg::PH_FNAME: begin
        cls = is_zero ? tpp_pkg::CLS_TERM : tpp_pkg::CLS_FNAME;
        if (is_zero) begin
          phase_next = tpp_pkg::PH_MODE;
        end
      end
      tpp_pkg::PH_MODE: begin
        cls = is_zero ? tpp_pkg::CLS_TERM : tpp_pkg::CLS_MODE;
        if (is_zero) begin
          phase_next = tpp_pkg::PH_ONAME;
          endst      = tpp_pkg::ST_OK;
        end
      end
      tpp_pkg::PH_ONAME: begin
        oidx = (option_counter > CW'(tpp_pkg::OIDX_MAX)) ? tpp_pkg::OIDX_MAX
                                                         : option_counter[3:0];
        cls  = is_zero ? tpp_pkg::CLS_TERM : tpp_pkg::CLS_ONAME;
        if (is_zero) begin
          phase_next = tpp_pkg::PH_OVAL;
        end
      end
      tpp_pkg::PH_OVAL: begin
        oidx = (option_counter > CW'(tpp_pkg::OIDX_MAX)) ? tpp_pkg::OIDX_MAX
                                                         : option_counter[3:0];
        cls  = is_zero ? tpp_pkg::CLS_TERM : tpp_pkg::CLS_OVAL;
        if (is_zero) begin
          if (option_counter < CW'(MAX_OPTIONS)) begin
            counter_upd = option_counter + CW'(1);
          end
          phase_next = tpp_pkg::PH_ONAME;
          endst      = tpp_pkg::ST_OK;
        end
      end
      tpp_pkg::PH_WHI: begin
        cls        = tpp_pkg::CLS_WORD;
        word_upd   = {item.data_byte, 8'd0};
        phase_next = tpp_pkg::PH_WLO;
      end
      tpp_pkg::PH_WLO: begin
        cls      = tpp_pkg::CLS_WORD;
        word_upd = {word_reg[15:8], item.data_byte};
        if (opcode_reg == tpp_pkg::OPC_DATA) begin
          phase_next = tpp_pkg::PH_PAYLOAD;
          endst      = tpp_pkg::ST_OK;
        end else if (opcode_reg == tpp_pkg::OPC_ACK) begin
          phase_next = tpp_pkg::PH_TRAILER;
          endst      = tpp_pkg::ST_OK;
        end else begin
          phase_next = tpp_pkg::PH_MESSAGE;
        end
      end
      tpp_pkg::PH_PAYLOAD: begin
        cls   = tpp_pkg::CLS_PAYLOAD;
        endst = tpp_pkg::ST_OK;
      end
      tpp_pkg::PH_MESSAGE: begin
        cls = is_zero ? tpp_pkg::CLS_TERM : tpp_pkg::CLS_MESSAGE;
        if (is_zero) begin
          phase_next = tpp_pkg::PH_TRAILER;
          endst      = tpp_pkg::ST_OK;
        end
      end
      tpp_pkg::PH_TRAILER: begin
        cls = tpp_pkg::CLS_TERM;
        if (trailer_count < tpp_pkg::TRAILER_MAX) begin
          trailer_upd = trailer_count + 2'd1;
        end
        if ((!is_zero || trailer_upd > 2'd1) && error_flag == tpp_pkg::ST_OK) begin
          error_upd = tpp_pkg::ST_MAL;
        end
        endst = tpp_pkg::ST_OK;
      end
      default: begin
        cls   = tpp_pkg::CLS_IGNORED;
        endst = (error_flag != tpp_pkg::ST_OK) ? error_flag : tpp_pkg::ST_MAL;
      end
    endcase

    if (item.last_byte) begin
      phase_next   = tpp_pkg::PH_OPC_HI;
      opcode_next  = '0;
      word_next    = '0;
      counter_next = '0;
      error_next   = '0;
      trailer_next = '0;
    end else begin
      opcode_next  = opcode_upd;
      word_next    = word_upd;
      counter_next = counter_upd;
      error_next   = error_upd;
      trailer_next = trailer_upd;
    end

    res_next.byte_out     = item.data_byte;
    res_next.byte_class   = cls;
    res_next.option_index = oidx;
    res_next.packet_end   = item.last_byte;
    res_next.opcode       = opcode_upd;
    res_next.word_value   = word_upd;
    res_next.option_count = counter_upd[4:0];
    if (item.last_byte) begin
      res_next.status = (error_upd != tpp_pkg::ST_OK) ? error_upd : endst;
    end else begin
      res_next.status = tpp_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

  assign results.valid        = res_valid;
  assign results.byte_out     = res.byte_out;
  assign results.byte_class   = res.byte_class;
  assign results.option_index = res.option_index;
  assign results.packet_end   = res.packet_end;
  assign results.opcode       = res.opcode;
  assign results.word_value   = res.word_value;
  assign results.option_count = res.option_count;
  assign results.status       = res.status;

endmodule
`default_nettype wire
